// ===== rtl/tlsc_pkg.sv =====
// shared types and constants for the two-list sort/concat block
package tlsc_pkg;

  localparam int MODE_W = 2;

  // run order codes held in the mode register
  localparam logic [MODE_W-1:0] MODE_ASC          = 2'd0;
  localparam logic [MODE_W-1:0] MODE_DESC         = 2'd1;
  localparam logic [MODE_W-1:0] MODE_FIRST_SECOND = 2'd2;
  localparam logic [MODE_W-1:0] MODE_SECOND_FIRST = 2'd3;

  // sequencer states, one-hot
  typedef enum logic [2:0] {
    ST_LOAD = 3'b001,
    ST_SORT = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // what every cell does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD  = 2'd0,
    OP_LOAD  = 2'd1,
    OP_SORT  = 2'd2,
    OP_SHIFT = 2'd3
  } cell_op_t;

  // control broadcast to the cell row
  typedef struct packed {
    cell_op_t              op;
    logic                  phase;
    logic [MODE_W-1:0]     mode;
  } cell_ctrl_t;

endpackage

// ===== rtl/tlsc_in_if.sv =====
// input channel: tagged values with an end-of-set mark
interface tlsc_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic                   from_second_list;
  logic [VALUE_WIDTH-1:0] value;
  logic                   last_of_set;

  modport source (output valid, output from_second_list, output value, output last_of_set,
                  input ready);
  modport sink (input valid, input from_second_list, input value, input last_of_set,
                output ready);
endinterface

// ===== rtl/tlsc_out_if.sv =====
// result channel: run elements with last and overflow flags
interface tlsc_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value_res;
  logic                   last_of_run;
  logic                   overflow;

  modport source (output valid, output value_res, output last_of_run, output overflow,
                  input ready);
  modport sink (input valid, input value_res, input last_of_run, input overflow,
                output ready);
endinterface

// ===== rtl/tlsc_cell.sv =====
// one cell of the row: holds an entry, loads, swaps with a neighbor or shifts down
module tlsc_cell #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  tlsc_pkg::cell_ctrl_t   ctrl,
  input  logic                   parity,
  input  logic                   load_sel,
  input  logic                   load_tag,
  input  logic [VALUE_WIDTH-1:0] load_value,
  input  logic                   left_valid,
  input  logic                   left_tag,
  input  logic [VALUE_WIDTH-1:0] left_value,
  input  logic                   right_valid,
  input  logic                   right_tag,
  input  logic [VALUE_WIDTH-1:0] right_value,
  output logic                   valid,
  output logic                   tag,
  output logic [VALUE_WIDTH-1:0] value
);

  logic                   valid_r, valid_nxt;
  logic                   tag_r, tag_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   lower;
  logic                   swap_lo;
  logic                   swap_hi;

  // strict order relation for the selected mode; strict keeps list order stable
  function automatic logic after_in_run(
    input logic                   a_tag,
    input logic [VALUE_WIDTH-1:0] a_val,
    input logic                   b_tag,
    input logic [VALUE_WIDTH-1:0] b_val,
    input logic [tlsc_pkg::MODE_W-1:0] mode
  );
    logic res;
    case (mode)
      tlsc_pkg::MODE_ASC:          res = $signed(a_val) > $signed(b_val);
      tlsc_pkg::MODE_DESC:         res = $signed(a_val) < $signed(b_val);
      tlsc_pkg::MODE_FIRST_SECOND: res = a_tag & ~b_tag;
      tlsc_pkg::MODE_SECOND_FIRST: res = ~a_tag & b_tag;
      default:                     res = 1'b0;
    endcase
    return res;
  endfunction

  // pair compare with right and left neighbor
  assign lower   = (parity == ctrl.phase);
  assign swap_lo = valid_r & right_valid &
                   after_in_run(tag_r, value_r, right_tag, right_value, ctrl.mode);
  assign swap_hi = left_valid & valid_r &
                   after_in_run(left_tag, left_value, tag_r, value_r, ctrl.mode);

  // next entry
  always_comb begin
    valid_nxt = valid_r;
    tag_nxt   = tag_r;
    value_nxt = value_r;
    case (ctrl.op)
      tlsc_pkg::OP_LOAD: begin
        if (load_sel) begin
          valid_nxt = 1'b1;
          tag_nxt   = load_tag;
          value_nxt = load_value;
        end
      end
      tlsc_pkg::OP_SORT: begin
        if (lower && swap_lo) begin
          valid_nxt = right_valid;
          tag_nxt   = right_tag;
          value_nxt = right_value;
        end else if (!lower && swap_hi) begin
          valid_nxt = left_valid;
          tag_nxt   = left_tag;
          value_nxt = left_value;
        end
      end
      tlsc_pkg::OP_SHIFT: begin
        valid_nxt = right_valid;
        tag_nxt   = right_tag;
        value_nxt = right_value;
      end
      default: begin
        valid_nxt = valid_r;
      end
    endcase
  end

  // entry registers, only valid is reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    tag_r   <= tag_nxt;
    value_r <= value_nxt;
  end

  assign valid = valid_r;
  assign tag   = tag_r;
  assign value = value_r;

endmodule

// ===== rtl/two_list_sort_or_concat.sv =====
// top level: two-list collector with sorted or concatenated output run
//
//   channel   dir   transfer when        payload
//   in_ch     in    valid & ready        from_second_list, value, last_of_set
//   out_ch    out   valid & ready        value_res, last_of_run, overflow
//   cfg       in    cfg_wr_en            cfg_wr_data (order mode)
//
// Each value stored on an input transfer is written into the next free cell of
// a row of 2*MAX_PER_LIST cells. The last item starts odd-even exchange passes
// over the cell row, then the run shifts out of cell 0 at one result per cycle
// while the output is not stalled; input is taken again after the last result
// has moved into the output register. Reset clears counts, flags and cell valid
// bits. A stalled output holds the chain; nothing is lost.
module two_list_sort_or_concat #(
  parameter int MAX_PER_LIST = 16,
  parameter int VALUE_WIDTH  = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic [tlsc_pkg::MODE_W-1:0] cfg_wr_data,
  tlsc_in_if.sink                     in_ch,
  tlsc_out_if.source                  out_ch
);

  localparam int CELLS = 2 * MAX_PER_LIST;
  localparam int CNT_W = $clog2(MAX_PER_LIST + 1);
  localparam int TOT_W = $clog2(CELLS + 1);

  tlsc_pkg::state_t            state_r, state_nxt;
  logic [CNT_W-1:0]            first_cnt_r, first_cnt_nxt;
  logic [CNT_W-1:0]            second_cnt_r, second_cnt_nxt;
  logic                        dropped_r, dropped_nxt;
  logic [tlsc_pkg::MODE_W-1:0] mode_r;
  logic [TOT_W-1:0]            round_r, round_nxt;
  logic [TOT_W-1:0]            remain_r, remain_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic [VALUE_WIDTH-1:0]      out_value_r;
  logic                        out_last_r;
  logic                        out_ovf_r;

  logic                        in_xfer;
  logic                        list_full;
  logic                        store;
  logic                        emit_go;
  logic [TOT_W-1:0]            total;
  tlsc_pkg::cell_ctrl_t        ctrl;

  logic                        cell_valid [CELLS];
  logic                        cell_tag   [CELLS];
  logic [VALUE_WIDTH-1:0]      cell_value [CELLS];

  // mode register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= tlsc_pkg::MODE_ASC;
    end else if (cfg_wr_en) begin
      mode_r <= cfg_wr_data;
    end
  end

  // input side
  assign in_ch.ready = (state_r == tlsc_pkg::ST_LOAD);
  assign in_xfer     = in_ch.valid & in_ch.ready;
  assign list_full   = in_ch.from_second_list ? (second_cnt_r == CNT_W'(MAX_PER_LIST))
                                              : (first_cnt_r == CNT_W'(MAX_PER_LIST));
  assign store       = in_xfer & ~list_full;
  assign total       = TOT_W'(first_cnt_r) + TOT_W'(second_cnt_r);
  assign emit_go     = (state_r == tlsc_pkg::ST_EMIT) & (~out_valid_r | out_ch.ready);

  // cell row control
  always_comb begin
    ctrl.mode  = mode_r;
    ctrl.phase = round_r[0];
    ctrl.op    = tlsc_pkg::OP_HOLD;
    case (state_r)
      tlsc_pkg::ST_LOAD: ctrl.op = store ? tlsc_pkg::OP_LOAD : tlsc_pkg::OP_HOLD;
      tlsc_pkg::ST_SORT: ctrl.op = tlsc_pkg::OP_SORT;
      tlsc_pkg::ST_EMIT: ctrl.op = emit_go ? tlsc_pkg::OP_SHIFT : tlsc_pkg::OP_HOLD;
      default:           ctrl.op = tlsc_pkg::OP_HOLD;
    endcase
  end

  // sequencer
  always_comb begin
    state_nxt      = state_r;
    first_cnt_nxt  = first_cnt_r;
    second_cnt_nxt = second_cnt_r;
    dropped_nxt    = dropped_r;
    round_nxt      = round_r;
    remain_nxt     = remain_r;
    case (state_r)
      tlsc_pkg::ST_LOAD: begin
        if (in_xfer) begin
          if (list_full) begin
            dropped_nxt = 1'b1;
          end else if (in_ch.from_second_list) begin
            second_cnt_nxt = second_cnt_r + CNT_W'(1);
          end else begin
            first_cnt_nxt = first_cnt_r + CNT_W'(1);
          end
          if (in_ch.last_of_set) begin
            state_nxt  = tlsc_pkg::ST_SORT;
            round_nxt  = '0;
            remain_nxt = total + TOT_W'(store);
          end
        end
      end
      tlsc_pkg::ST_SORT: begin
        round_nxt = round_r + TOT_W'(1);
        if (round_r == remain_r - TOT_W'(1)) begin
          state_nxt = tlsc_pkg::ST_EMIT;
        end
      end
      tlsc_pkg::ST_EMIT: begin
        if (emit_go) begin
          remain_nxt = remain_r - TOT_W'(1);
          if (remain_r == TOT_W'(1)) begin
            state_nxt      = tlsc_pkg::ST_LOAD;
            first_cnt_nxt  = '0;
            second_cnt_nxt = '0;
            dropped_nxt    = 1'b0;
          end
        end
      end
      default: begin
        state_nxt = tlsc_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tlsc_pkg::ST_LOAD;
      first_cnt_r  <= '0;
      second_cnt_r <= '0;
      dropped_r    <= 1'b0;
      round_r      <= '0;
      remain_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      first_cnt_r  <= first_cnt_nxt;
      second_cnt_r <= second_cnt_nxt;
      dropped_r    <= dropped_nxt;
      round_r      <= round_nxt;
      remain_r     <= remain_nxt;
    end
  end

  // output register fed from cell 0
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    if (emit_go) begin
      out_value_r <= cell_value[0];
      out_last_r  <= (remain_r == TOT_W'(1));
      out_ovf_r   <= dropped_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.value_res   = out_value_r;
  assign out_ch.last_of_run = out_last_r;
  assign out_ch.overflow    = out_ovf_r;

  // row of cells, neighbors wired left and right, ends see empty entries
  for (genvar i = 0; i < CELLS; i++) begin : g_cell
    logic                   lv, lt, rv, rt;
    logic [VALUE_WIDTH-1:0] lval, rval;

    if (i == 0) begin : g_left_end
      assign lv   = 1'b0;
      assign lt   = 1'b0;
      assign lval = '0;
    end else begin : g_left
      assign lv   = cell_valid[i-1];
      assign lt   = cell_tag[i-1];
      assign lval = cell_value[i-1];
    end

    if (i == CELLS - 1) begin : g_right_end
      assign rv   = 1'b0;
      assign rt   = 1'b0;
      assign rval = '0;
    end else begin : g_right
      assign rv   = cell_valid[i+1];
      assign rt   = cell_tag[i+1];
      assign rval = cell_value[i+1];
    end

    tlsc_cell #(
      .VALUE_WIDTH (VALUE_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .parity      (1'(i % 2)),
      .load_sel    (total == TOT_W'(i)),
      .load_tag    (in_ch.from_second_list),
      .load_value  (in_ch.value),
      .left_valid  (lv),
      .left_tag    (lt),
      .left_value  (lval),
      .right_valid (rv),
      .right_tag   (rt),
      .right_value (rval),
      .valid       (cell_valid[i]),
      .tag         (cell_tag[i]),
      .value       (cell_value[i])
    );
  end

endmodule

// ===== tb/two_list_sort_or_concat_tb.sv =====
// testbench for two_list_sort_or_concat: directed table, random sets, sorted-run checker
module two_list_sort_or_concat_tb;

  localparam int LIST_DEPTH  = 16;
  localparam int VW          = 32;
  localparam int RAND_ITEMS  = 160;
  localparam int SETTLE      = 8;
  localparam int DRAIN       = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;
  localparam int N_ROWS      = 21;

  // one element of an output run
  typedef struct packed {
    logic [VW-1:0] value;
    logic          last;
    logic          ovf;
  } run_elem_t;

  // one row of the directed table; reps > 1 repeats the item, value stepping by step
  typedef struct packed {
    logic [tlsc_pkg::MODE_W-1:0] mode;
    logic                        second;
    logic [VW-1:0]               value;
    int                          step;
    int                          reps;
    logic                        last;
    logic                        typed;
    logic [VW-1:0]               exp_value;
    logic                        exp_ovf;
  } stim_row_t;

  stim_row_t dir_rows [N_ROWS] = '{
    // single values right after reset, extremes
    '{tlsc_pkg::MODE_ASC, 1'b0, 32'h7FFF_FFFF, 0, 1, 1'b1, 1'b1, 32'h7FFF_FFFF, 1'b0},
    '{tlsc_pkg::MODE_ASC, 1'b1, 32'h8000_0000, 0, 1, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
    // ascending with equal values and extremes across both lists
    '{tlsc_pkg::MODE_ASC, 1'b0, 32'h0000_0005, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_ASC, 1'b1, 32'hFFFF_FFFD, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_ASC, 1'b0, 32'hFFFF_FFFD, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_ASC, 1'b1, 32'h7FFF_FFFF, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_ASC, 1'b0, 32'h8000_0000, 0, 1, 1'b1, 1'b0, '0, 1'b0},
    // descending
    '{tlsc_pkg::MODE_DESC, 1'b1, 32'h0000_0001, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_DESC, 1'b0, 32'hFFFF_FFFF, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_DESC, 1'b1, 32'h0000_0000, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_DESC, 1'b0, 32'h8000_0000, 0, 1, 1'b1, 1'b0, '0, 1'b0},
    // first list then second, arrival order kept
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b1, 32'd10, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b0, 32'd20, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b1, 32'd30, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b0, 32'd40, 0, 1, 1'b1, 1'b0, '0, 1'b0},
    // second list then first
    '{tlsc_pkg::MODE_SECOND_FIRST, 1'b0, 32'd1, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_SECOND_FIRST, 1'b1, 32'd2, 0, 1, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_SECOND_FIRST, 1'b0, 32'd3, 0, 1, 1'b1, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_SECOND_FIRST, 1'b1, 32'hFFFF_FFFF, 0, 1, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b0},
    // fill the first list, then the closing item meets the full list and is dropped
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b0, 32'd100, -7, 16, 1'b0, 1'b0, '0, 1'b0},
    '{tlsc_pkg::MODE_FIRST_SECOND, 1'b0, 32'd0, 0, 1, 1'b1, 1'b0, '0, 1'b0}
  };

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [tlsc_pkg::MODE_W-1:0] cfg_wr_data;

  tlsc_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  tlsc_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  two_list_sort_or_concat #(
    .MAX_PER_LIST(LIST_DEPTH),
    .VALUE_WIDTH (VW)
  ) uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // shadow of the block state
  logic [VW-1:0]               first_vals  [LIST_DEPTH];
  logic [VW-1:0]               second_vals [LIST_DEPTH];
  int                          first_cnt;
  int                          second_cnt;
  bit                          dropped;
  logic [tlsc_pkg::MODE_W-1:0] mode_shadow;

  run_elem_t fresh_run [$];
  run_elem_t pending_run [$];

  int mismatches;
  int cycles;
  int rand_items;
  bit sender_fast;
  bit hold_off_req;
  bit hold_done;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // store one value, and on the closing item build the expected run
  function automatic void predict_item(bit second, logic [VW-1:0] v, bit last);
    logic [VW-1:0] run [$];
    logic [VW-1:0] t;
    int j;
    bit desc;
    run_elem_t e;
    fresh_run.delete();
    if (second) begin
      if (second_cnt < LIST_DEPTH) begin
        second_vals[second_cnt] = v;
        second_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end else begin
      if (first_cnt < LIST_DEPTH) begin
        first_vals[first_cnt] = v;
        first_cnt++;
      end else begin
        dropped = 1'b1;
      end
    end
    if (!last) return;
    if (mode_shadow == tlsc_pkg::MODE_FIRST_SECOND) begin
      for (int i = 0; i < first_cnt; i++) run.push_back(first_vals[i]);
      for (int i = 0; i < second_cnt; i++) run.push_back(second_vals[i]);
    end else begin
      for (int i = 0; i < second_cnt; i++) run.push_back(second_vals[i]);
      for (int i = 0; i < first_cnt; i++) run.push_back(first_vals[i]);
    end
    // insertion sort on signed values for the two sorted orders
    if (mode_shadow == tlsc_pkg::MODE_ASC || mode_shadow == tlsc_pkg::MODE_DESC) begin
      desc = (mode_shadow == tlsc_pkg::MODE_DESC);
      for (int i = 1; i < run.size(); i++) begin
        t = run[i];
        j = i - 1;
        while (j >= 0 && (desc ? ($signed(run[j]) < $signed(t))
                               : ($signed(run[j]) > $signed(t)))) begin
          run[j+1] = run[j];
          j--;
        end
        run[j+1] = t;
      end
    end
    for (int i = 0; i < run.size(); i++) begin
      e.value = run[i];
      e.last  = (i == run.size() - 1);
      e.ovf   = dropped;
      fresh_run.push_back(e);
    end
    first_cnt  = 0;
    second_cnt = 0;
    dropped    = 1'b0;
  endfunction

  // random value, weighted toward extremes and small duplicates
  function automatic logic [VW-1:0] rand_value();
    logic [VW-1:0] edges [4] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
    case ($urandom_range(0, 7))
      0: return edges[$urandom_range(0, 3)];
      1: return 32'($urandom_range(0, 6)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  function automatic int draw_gap();
    return sender_fast ? 0 : $urandom_range(0, 11);
  endfunction

  // offer one item and hold it until the transfer, then record what it causes
  task automatic offer_item(input bit second, input logic [VW-1:0] v, input bit last,
                            input bit typed, input logic [VW-1:0] exp_value,
                            input bit exp_ovf);
    int gap;
    run_elem_t e;
    gap = draw_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid            <= 1'b1;
    in_ch.from_second_list <= second;
    in_ch.value            <= v;
    in_ch.last_of_set      <= last;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    predict_item(second, v, last);
    if (typed) begin
      e.value = exp_value;
      e.last  = 1'b1;
      e.ovf   = exp_ovf;
      pending_run.push_back(e);
    end else begin
      foreach (fresh_run[i]) pending_run.push_back(fresh_run[i]);
    end
  endtask

  // stop offering and wait until every expected result has come
  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_run.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_mode(input logic [tlsc_pkg::MODE_W-1:0] m);
    wait_idle();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    mode_shadow = m;
  endtask

  // result checker
  always @(posedge clk) begin
    run_elem_t e;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_run.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected result: value %h last %b ovf %b",
                   out_ch.value_res, out_ch.last_of_run, out_ch.overflow);
        mismatches++;
      end else begin
        e = pending_run.pop_front();
        if (out_ch.value_res !== e.value || out_ch.last_of_run !== e.last ||
            out_ch.overflow !== e.ovf) begin
          if (mismatches < 10)
            $display("mismatch: exp value %h last %b ovf %b, got value %h last %b ovf %b",
                     e.value, e.last, e.ovf,
                     out_ch.value_res, out_ch.last_of_run, out_ch.overflow);
          mismatches++;
        end
      end
    end
  end

  // result receiver: random stalls, stall-free stretches, one long hold-off
  initial begin
    bit rx_fast;
    int stall;
    rx_fast = 1'b0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_off_req && !hold_done) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        if ($urandom_range(0, 15) == 0) rx_fast = ~rx_fast;
        stall = rx_fast ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          out_ch.ready <= 1'b0;
          repeat (stall) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
    end
  end

  // stimulus
  initial begin
    int kind;
    int len;
    bit home;
    bit sec;
    rand_items   = 0;
    hold_off_req = 1'b0;
    sender_fast  = 1'b0;
    first_cnt    = 0;
    second_cnt   = 0;
    dropped      = 1'b0;
    mode_shadow  = tlsc_pkg::MODE_ASC;
    rst_n                  <= 1'b0;
    cfg_wr_en              <= 1'b0;
    cfg_wr_data            <= '0;
    in_ch.valid            <= 1'b0;
    in_ch.from_second_list <= 1'b0;
    in_ch.value            <= '0;
    in_ch.last_of_set      <= 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table
    write_mode(tlsc_pkg::MODE_ASC);
    for (int r = 0; r < N_ROWS; r++) begin
      if (dir_rows[r].mode != mode_shadow) write_mode(dir_rows[r].mode);
      sender_fast = ($urandom_range(0, 2) == 0);
      for (int k = 0; k < dir_rows[r].reps; k++)
        offer_item(dir_rows[r].second, dir_rows[r].value + 32'(k * dir_rows[r].step),
                   dir_rows[r].last, dir_rows[r].typed, dir_rows[r].exp_value,
                   dir_rows[r].exp_ovf);
    end

    // random sets; the receiver holds off once while sets keep coming
    hold_off_req = 1'b1;
    while (rand_items < RAND_ITEMS) begin
      // mode changes wait until the long hold-off is over
      if (hold_done && $urandom_range(0, 3) == 0)
        write_mode(tlsc_pkg::MODE_W'($urandom_range(0, 3)));
      sender_fast = ($urandom_range(0, 3) == 0);
      kind = $urandom_range(0, 9);
      home = 1'($urandom_range(0, 1));
      if (kind <= 5)      len = $urandom_range(1, 8);
      else if (kind <= 7) len = $urandom_range(9, 24);
      else if (kind == 8) len = $urandom_range(17, 22);
      else                len = $urandom_range(30, 36);
      for (int k = 0; k < len; k++) begin
        // overflow sets aim most items at one list
        if (kind == 8) sec = ($urandom_range(0, 4) == 0) ? ~home : home;
        else           sec = 1'($urandom_range(0, 1));
        offer_item(sec, rand_value(), k == len - 1, 1'b0, '0, 1'b0);
        rand_items++;
      end
    end

    wait_idle();
    repeat (DRAIN) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
